// ===== rtl/graph_depth_first_search_assert.svh =====
// Assertion macros for the depth-first search block.
// Used by the port checker; needs nothing else.
`ifndef GRAPH_DEPTH_FIRST_SEARCH_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_SEARCH_ASSERT_SVH

// Property that holds on every clock edge outside reset.
`define GDFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent now implies consequent on the next edge.
`define GDFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gdfs_pkg.sv =====
// Shared types and constants of the depth-first search block.
// No dependencies.
package gdfs_pkg;

    localparam int MAX_VERTICES_DEF = 8;
    localparam int ACT_W            = 2;
    localparam int LABEL_W          = 8;
    localparam int EDGE_W           = 3;
    localparam int VIS_W            = 3;

    typedef logic [VIS_W-1:0]   t_vis_idx;
    typedef logic [LABEL_W-1:0] t_label;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_VERTEX = 2'd0,
        ACT_ADD_EDGE   = 2'd1,
        ACT_SEARCH     = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_POP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic apply;      // item accepted: apply its action
        logic init;       // push vertex 0 and mark it
        logic scan;       // one neighbor scan of the stack top
        logic pop_load;   // take the new stack top from the stack read
        logic emit_load;  // load the output register
    } t_cmd;

    typedef struct packed {
        logic total_zero;
        logic found;
        logic last_pop;
        logic slot_free;
        logic emit_last;
    } t_sts;

endpackage

// ===== rtl/graph_depth_first_search.sv =====
// Top level of the depth-first search block over an adjacency-matrix graph.
// Depends on gdfs_pkg, gdfs_ctrl and gdfs_dp.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_stall   action, vertex_label, edge_from, edge_to
//   out      from block o_out_valid / i_out_stall visited_index, visited_label, last_visit
//
// Add vertex, add edge and clear are applied on acceptance and leave the input open.
// A search pushes vertex 0, then scans the stack top's adjacency row: the lowest unvisited
// neighbor is pushed and marked, and if there is none the stack is popped.
// Each result waits one visit in a holding register so the last can be marked.
// A stalled output holds the search in its emit state; input is stalled until done.
// Reset is synchronous, active low, and empties the graph.
module graph_depth_first_search #(
    parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_vertex_label,
    input  logic [2:0] i_edge_from,
    input  logic [2:0] i_edge_to,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_visited_index,
    output logic [7:0] o_visited_label,
    output logic       o_last_visit
);

    gdfs_pkg::t_cmd w_cmd;
    gdfs_pkg::t_sts w_sts;

    gdfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    gdfs_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_action),
        .i_vertex_label  (i_vertex_label),
        .i_edge_from     (i_edge_from),
        .i_edge_to       (i_edge_to),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_visited_index (o_visited_index),
        .o_visited_label (o_visited_label),
        .o_last_visit    (o_last_visit)
    );

endmodule

// ===== rtl/gdfs_ctrl.sv =====
// Controller state machine of the depth-first search block.
// Depends on gdfs_pkg; drives commands to gdfs_dp.
module gdfs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_action,
    input  gdfs_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output gdfs_pkg::t_cmd  o_cmd
);

    gdfs_pkg::t_state r_state;
    gdfs_pkg::t_state n_state;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == gdfs_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gdfs_pkg::ST_IDLE: begin
                if (w_accept && (gdfs_pkg::t_action'(i_action) == gdfs_pkg::ACT_SEARCH)
                    && !i_sts.total_zero) begin
                    n_state = gdfs_pkg::ST_INIT;
                end
            end
            gdfs_pkg::ST_INIT: begin
                n_state = gdfs_pkg::ST_SCAN;
            end
            gdfs_pkg::ST_SCAN: begin
                if (i_sts.found || i_sts.last_pop) begin
                    n_state = gdfs_pkg::ST_EMIT;
                end else begin
                    n_state = gdfs_pkg::ST_POP;
                end
            end
            gdfs_pkg::ST_POP: begin
                n_state = gdfs_pkg::ST_SCAN;
            end
            gdfs_pkg::ST_EMIT: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.emit_last ? gdfs_pkg::ST_IDLE : gdfs_pkg::ST_SCAN;
                end
            end
            default: begin
                n_state = gdfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != gdfs_pkg::ST_IDLE);
        unique case (r_state)
            gdfs_pkg::ST_IDLE: o_cmd.apply     = w_accept;
            gdfs_pkg::ST_INIT: o_cmd.init      = 1'b1;
            gdfs_pkg::ST_SCAN: o_cmd.scan      = 1'b1;
            gdfs_pkg::ST_POP:  o_cmd.pop_load  = 1'b1;
            gdfs_pkg::ST_EMIT: o_cmd.emit_load = i_sts.slot_free;
            default:           o_cmd           = '0;
        endcase
    end

endmodule

// ===== rtl/gdfs_dp.sv =====
// Datapath of the depth-first search block: graph store, stack, scan, output.
// Depends on gdfs_pkg; commanded by gdfs_ctrl.
module gdfs_dp #(
    parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [1:0]              i_action,
    input  logic [7:0]              i_vertex_label,
    input  logic [2:0]              i_edge_from,
    input  logic [2:0]              i_edge_to,
    input  logic                    i_out_stall,
    input  gdfs_pkg::t_cmd          i_cmd,
    output gdfs_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    output logic [2:0]              o_visited_index,
    output logic [7:0]              o_visited_label,
    output logic                    o_last_visit
);

    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CW > gdfs_pkg::EDGE_W) ? CW : gdfs_pkg::EDGE_W;

    typedef logic [VW-1:0]    t_vidx;
    typedef logic [CW-1:0]    t_cnt;
    typedef logic [CMP_W-1:0] t_cmp;

    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    gdfs_pkg::t_label        r_lbl_mem [MAX_VERTICES];
    t_vidx                   r_stk_mem [MAX_VERTICES];

    t_cnt                    r_total;
    t_cnt                    r_fill;
    logic [MAX_VERTICES-1:0] r_visited;
    t_vidx                   r_top;
    t_vidx                   r_pend;
    t_vidx                   r_emit_idx;
    logic                    r_emit_last;
    gdfs_pkg::t_label        r_lbl_rd;
    t_vidx                   r_stk_rd;
    logic                    r_out_vld;
    gdfs_pkg::t_vis_idx      r_out_idx;
    gdfs_pkg::t_label        r_out_lbl;
    logic                    r_out_last;

    gdfs_pkg::t_action       w_act;
    logic                    w_edge_ok;
    t_vidx                   w_ea;
    t_vidx                   w_eb;
    logic [MAX_VERTICES-1:0] w_ea_bit;
    logic [MAX_VERTICES-1:0] w_eb_bit;
    logic [MAX_VERTICES-1:0] w_live;
    logic [MAX_VERTICES-1:0] w_cand;
    t_vidx                   w_nb;
    logic                    w_found;
    t_cnt                    w_fill_m2;
    logic                    w_slot_free;

    assign w_act     = gdfs_pkg::t_action'(i_action);
    assign w_edge_ok = (t_cmp'(i_edge_from) < t_cmp'(MAX_VERTICES))
                    && (t_cmp'(i_edge_to) < t_cmp'(MAX_VERTICES));
    assign w_ea      = t_vidx'(i_edge_from);
    assign w_eb      = t_vidx'(i_edge_to);
    assign w_ea_bit  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << w_ea;
    assign w_eb_bit  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << w_eb;
    assign w_fill_m2 = r_fill - t_cnt'(2);
    assign w_slot_free = !r_out_vld || !i_out_stall;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_live[i] = (t_cnt'(i) < r_total);
        end
    end

    assign w_cand  = r_adj[r_top] & ~r_visited & w_live;
    assign w_found = |w_cand;

    // lowest set candidate wins
    always_comb begin
        w_nb = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_nb = t_vidx'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj <= '{default: '0};
        end else if (i_cmd.apply) begin
            if (w_act == gdfs_pkg::ACT_CLEAR) begin
                r_adj <= '{default: '0};
            end else if (w_act == gdfs_pkg::ACT_ADD_EDGE && w_edge_ok) begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    r_adj[i] <= r_adj[i] | ((t_vidx'(i) == w_ea) ? w_eb_bit : '0)
                                         | ((t_vidx'(i) == w_eb) ? w_ea_bit : '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && w_act == gdfs_pkg::ACT_ADD_VERTEX
            && r_total < t_cnt'(MAX_VERTICES)) begin
            r_lbl_mem[r_total[VW-1:0]] <= i_vertex_label;
        end
        if (i_cmd.scan) begin
            r_lbl_rd <= r_lbl_mem[r_pend];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_stk_mem[t_vidx'(0)] <= t_vidx'(0);
        end else if (i_cmd.scan && w_found) begin
            r_stk_mem[r_fill[VW-1:0]] <= w_nb;
        end
        if (i_cmd.scan && !w_found) begin
            r_stk_rd <= r_stk_mem[w_fill_m2[VW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_fill    <= '0;
            r_visited <= '0;
        end else if (i_cmd.apply) begin
            priority case (w_act)
                gdfs_pkg::ACT_ADD_VERTEX: begin
                    if (r_total < t_cnt'(MAX_VERTICES)) begin
                        r_total <= r_total + t_cnt'(1);
                    end
                end
                gdfs_pkg::ACT_SEARCH: begin
                    r_fill    <= '0;
                    r_visited <= '0;
                end
                gdfs_pkg::ACT_CLEAR: begin
                    r_total   <= '0;
                    r_fill    <= '0;
                    r_visited <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.init) begin
            r_fill    <= t_cnt'(1);
            r_visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
        end else if (i_cmd.scan) begin
            if (w_found) begin
                r_visited[w_nb] <= 1'b1;
                r_fill          <= r_fill + t_cnt'(1);
            end else begin
                r_fill          <= r_fill - t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_top  <= '0;
            r_pend <= '0;
        end else if (i_cmd.scan) begin
            r_emit_idx <= r_pend;
            if (w_found) begin
                r_top       <= w_nb;
                r_pend      <= w_nb;
                r_emit_last <= 1'b0;
            end else begin
                r_emit_last <= 1'b1;
            end
        end else if (i_cmd.pop_load) begin
            r_top <= r_stk_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_idx  <= gdfs_pkg::t_vis_idx'(r_emit_idx);
            r_out_lbl  <= r_lbl_rd;
            r_out_last <= r_emit_last;
        end
    end

    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.found      = w_found;
    assign o_sts.last_pop   = (r_fill == t_cnt'(1));
    assign o_sts.slot_free  = w_slot_free;
    assign o_sts.emit_last  = r_emit_last;

    assign o_out_valid     = r_out_vld;
    assign o_visited_index = r_out_idx;
    assign o_visited_label = r_out_lbl;
    assign o_last_visit    = r_out_last;

endmodule

// ===== rtl/gdfs_chk.sv =====
// Port checker for the depth-first search block, bound to the top level.
// Depends on gdfs_pkg and graph_depth_first_search_assert.svh.
`include "graph_depth_first_search_assert.svh"

module gdfs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_action,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_visited_index,
    input logic [7:0] o_visited_label,
    input logic       o_last_visit
);

    logic w_in_acc;
    logic w_nonsearch;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_nonsearch = (i_action != gdfs_pkg::ACT_SEARCH);

    `GDFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_visited_index) && $stable(o_visited_label) && $stable(o_last_visit), "stalled item changed")
    `GDFS_ASSERT_NEXT(a_quick_action, i_clk, i_rst_n, w_in_acc && w_nonsearch, !o_in_stall, "non-search item stalled input")
    `GDFS_ASSERT(a_busy_mid_search, i_clk, i_rst_n, !(o_out_valid && !o_last_visit) || o_in_stall, "input open before last visit")
    `GDFS_ASSERT(a_idle_after_reset, i_clk, i_rst_n, !$past(!i_rst_n) || !o_in_stall, "stall right after reset")

endmodule

bind graph_depth_first_search gdfs_chk u_gdfs_chk (.*);
